// ----- rtl/core/wesa_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted edge scatter-accumulate package
// Item formats, queue command format, codes and fixed constants shared by the
// front end, the command queue, the back end and the top level.
// ----------------------------------------------------------------------------
package wesa_pkg;

    // Fixed field widths of the item formats.
    localparam int NODE_W     = 10;
    localparam int COL_W      = 6;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int MODE_W     = 2;

    // Configuration register widths and port format.
    localparam int COUNT_W    = 11;
    localparam int FW_W       = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_COUNT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEATURE_WIDTH = 2'd2;

    localparam logic [COUNT_W-1:0] TARGET_COUNT_RESET  = 11'd1024;
    localparam logic [COUNT_W-1:0] SOURCE_COUNT_RESET  = 11'd1024;
    localparam logic [FW_W-1:0]    FEATURE_WIDTH_RESET = 7'd1;

    // Item mode codes.
    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EDGE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

    // Q16.16 saturation limits.
    localparam logic [VALUE_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] Q_MIN = 32'h8000_0000;

    // Depth of the command queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [NODE_W-1:0]         target_node;
        logic [NODE_W-1:0]         source_node;
        logic [COL_W-1:0]          column;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [STATUS_W-1:0]       status;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_EDGE,
        OP_READ,
        OP_REJECT
    } op_t;

    // A classified item as it travels through the command queue.
    typedef struct packed {
        op_t                       op;
        logic [NODE_W-1:0]         target_node;
        logic [NODE_W-1:0]         source_node;
        logic [COL_W-1:0]          column;
        logic signed [VALUE_W-1:0] value;
        logic [FW_W-1:0]           feat_cols;
    } cmd_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_EDGE,
        B_READ,
        B_DONE
    } back_state_t;

endpackage

// ----- rtl/core/wesa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port; read data is registered and returns the
// old contents when the same address is written in the same cycle.
// ----------------------------------------------------------------------------
module wesa_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/wesa_front.sv -----
// ----------------------------------------------------------------------------
// Weighted edge scatter-accumulate front end
// Holds the configuration registers, accepts items and classifies each one
// into a load, edge, read or rejected command for the queue.
// ----------------------------------------------------------------------------
module wesa_front #(
    parameter int MAX_TARGET_NODES  = 1024,
    parameter int MAX_SOURCE_NODES  = 1024,
    parameter int MAX_FEATURE_WIDTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [wesa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [wesa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  wesa_pkg::in_item_t                 in_data,
    input  logic                               clearing,
    input  logic                               queue_full,
    output logic                               cmd_push,
    output wesa_pkg::cmd_t                     cmd_data
);
    import wesa_pkg::*;

    logic [COUNT_W-1:0] target_count_reg;
    logic [COUNT_W-1:0] source_count_reg;
    logic [FW_W-1:0]    feature_width_reg;

    logic [FW_W-1:0]    fw_eff;
    logic               tgt_ok;
    logic               src_ok;
    logic               col_ok;
    op_t                op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_count_reg  <= TARGET_COUNT_RESET;
            source_count_reg  <= SOURCE_COUNT_RESET;
            feature_width_reg <= FEATURE_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET_COUNT:  target_count_reg  <= cfg_wdata;
                CFG_SOURCE_COUNT:  source_count_reg  <= cfg_wdata;
                CFG_FEATURE_WIDTH: feature_width_reg <= cfg_wdata[FW_W-1:0];
                default: ;
            endcase
        end
    end

    // Register values above the storage limits act as the limits.
    always_comb
    begin
        fw_eff = (int'(feature_width_reg) > MAX_FEATURE_WIDTH) ?
                 FW_W'(MAX_FEATURE_WIDTH) : feature_width_reg;
        tgt_ok = (int'(in_data.target_node) < int'(target_count_reg)) &&
                 (int'(in_data.target_node) < MAX_TARGET_NODES);
        src_ok = (int'(in_data.source_node) < int'(source_count_reg)) &&
                 (int'(in_data.source_node) < MAX_SOURCE_NODES);
        col_ok = FW_W'(in_data.column) < fw_eff;

        case (in_data.mode)
            MODE_LOAD: op = (src_ok && col_ok) ? OP_LOAD : OP_REJECT;
            MODE_EDGE: op = (tgt_ok && src_ok) ? OP_EDGE : OP_REJECT;
            MODE_READ: op = (tgt_ok && col_ok) ? OP_READ : OP_REJECT;
            default:   op = OP_REJECT;
        endcase
    end

    assign in_ready = !clearing && !queue_full;
    assign cmd_push = in_valid && in_ready;

    assign cmd_data = '{
        op:          op,
        target_node: in_data.target_node,
        source_node: in_data.source_node,
        column:      in_data.column,
        value:       in_data.value,
        feat_cols:   fw_eff
    };

endmodule

// ----- rtl/core/wesa_queue.sv -----
// ----------------------------------------------------------------------------
// Weighted edge scatter-accumulate command queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module wesa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wesa_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output wesa_pkg::cmd_t pop_data,
    output logic           avail
);
    import wesa_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign avail    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];

endmodule

// ----- rtl/core/wesa_back.sv -----
// ----------------------------------------------------------------------------
// Weighted edge scatter-accumulate back end
// Owns the feature and accumulator memories, clears the accumulators after
// reset, and runs queued commands, edges through a multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module wesa_back #(
    parameter int MAX_TARGET_NODES  = 1024,
    parameter int MAX_SOURCE_NODES  = 1024,
    parameter int MAX_FEATURE_WIDTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_pop,
    input  wesa_pkg::cmd_t      cmd_data,
    output logic                clearing,
    output logic                out_valid,
    input  logic                out_ready,
    output wesa_pkg::out_item_t out_data
);
    import wesa_pkg::*;

    localparam int FEAT_DEPTH = MAX_SOURCE_NODES * MAX_FEATURE_WIDTH;
    localparam int ACC_DEPTH  = MAX_TARGET_NODES * MAX_FEATURE_WIDTH;
    localparam int FEAT_AW    = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
    localparam int ACC_AW     = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;

    back_state_t               state_reg;
    back_state_t               state_next;
    logic [ACC_AW-1:0]         clr_addr_reg;
    logic [ACC_AW-1:0]         clr_addr_next;
    logic [FW_W-1:0]           j_reg;
    logic [FW_W-1:0]           j_next;
    logic [FW_W-1:0]           fw_reg;
    logic [FW_W-1:0]           fw_next;
    logic signed [VALUE_W-1:0] weight_reg;
    logic signed [VALUE_W-1:0] weight_next;
    logic [FEAT_AW-1:0]        feat_base_reg;
    logic [FEAT_AW-1:0]        feat_base_next;
    logic [ACC_AW-1:0]         acc_base_reg;
    logic [ACC_AW-1:0]         acc_base_next;
    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic [ACC_AW-1:0]         s1_addr_reg;
    logic [ACC_AW-1:0]         s1_addr_next;
    logic                      s2_valid_reg;
    logic                      s2_valid_next;
    logic [ACC_AW-1:0]         s2_addr_reg;
    logic [ACC_AW-1:0]         s2_addr_next;
    logic signed [63:0]        prod_reg;
    logic signed [63:0]        prod_next;
    logic [VALUE_W-1:0]        acc_hold_reg;
    logic [VALUE_W-1:0]        acc_hold_next;
    logic                      sat_reg;
    logic                      sat_next;
    out_item_t                 res_reg;
    out_item_t                 res_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    out_item_t                 out_data_reg;
    out_item_t                 out_data_next;

    logic                      feat_we;
    logic [FEAT_AW-1:0]        feat_waddr;
    logic [VALUE_W-1:0]        feat_wdata;
    logic [FEAT_AW-1:0]        feat_raddr;
    logic [VALUE_W-1:0]        feat_rdata;
    logic                      acc_we;
    logic [ACC_AW-1:0]         acc_waddr;
    logic [VALUE_W-1:0]        acc_wdata;
    logic [ACC_AW-1:0]         acc_raddr;
    logic [VALUE_W-1:0]        acc_rdata;

    logic                      issue;
    logic [FEAT_AW-1:0]        load_addr;
    logic [ACC_AW-1:0]         read_addr;
    logic [ACC_AW-1:0]         edge_addr;
    logic [48:0]               sum_full;
    logic                      sat_hi;
    logic                      sat_lo;
    logic [VALUE_W-1:0]        sum_sat;

    wesa_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (FEAT_DEPTH)
    ) u_feat_ram (
        .clk   (clk),
        .we    (feat_we),
        .waddr (feat_waddr),
        .wdata (feat_wdata),
        .raddr (feat_raddr),
        .rdata (feat_rdata)
    );

    wesa_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (ACC_DEPTH)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // Element (row, column) lives at row * MAX_FEATURE_WIDTH + column.
    assign load_addr = FEAT_AW'(cmd_data.source_node) * FEAT_AW'(MAX_FEATURE_WIDTH)
                     + FEAT_AW'(cmd_data.column);
    assign read_addr = ACC_AW'(cmd_data.target_node) * ACC_AW'(MAX_FEATURE_WIDTH)
                     + ACC_AW'(cmd_data.column);
    assign edge_addr = acc_base_reg + ACC_AW'(j_reg);
    assign issue     = (state_reg == B_EDGE) && (j_reg < fw_reg);

    // The product is floored to Q16.16 by dropping its low 16 bits, then added
    // at full width and clamped to the 32-bit range.
    always_comb
    begin
        sum_full = {{17{acc_hold_reg[VALUE_W-1]}}, acc_hold_reg}
                 + {prod_reg[63], prod_reg[63:16]};
        sat_hi   = !sum_full[48] && (sum_full[47:31] != '0);
        sat_lo   = sum_full[48] && (sum_full[47:31] != '1);
        sum_sat  = sat_hi ? Q_MAX : (sat_lo ? Q_MIN : sum_full[31:0]);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        j_next         = j_reg;
        fw_next        = fw_reg;
        weight_next    = weight_reg;
        feat_base_next = feat_base_reg;
        acc_base_next  = acc_base_reg;
        sat_next       = sat_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cmd_pop        = 1'b0;

        // Multiply-accumulate pipeline: read, multiply, add and write back.
        s1_valid_next  = issue;
        s1_addr_next   = edge_addr;
        s2_valid_next  = s1_valid_reg;
        s2_addr_next   = s1_addr_reg;
        prod_next      = $signed(feat_rdata) * weight_reg;
        acc_hold_next  = acc_rdata;

        feat_we        = 1'b0;
        feat_waddr     = load_addr;
        feat_wdata     = cmd_data.value;
        feat_raddr     = feat_base_reg + FEAT_AW'(j_reg);
        acc_we         = 1'b0;
        acc_waddr      = s2_addr_reg;
        acc_wdata      = sum_sat;
        acc_raddr      = edge_addr;

        if (s2_valid_reg)
        begin
            acc_we = 1'b1;
            if (sat_hi || sat_lo)
            begin
                sat_next = 1'b1;
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_CLEAR:
            begin
                acc_we        = 1'b1;
                acc_waddr     = clr_addr_reg;
                acc_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ACC_AW'(ACC_DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd_data.op)
                        OP_LOAD:
                        begin
                            feat_we    = 1'b1;
                            res_next   = '{read_value: '0, status: STATUS_OK};
                            state_next = B_DONE;
                        end
                        OP_EDGE:
                        begin
                            j_next         = '0;
                            fw_next        = cmd_data.feat_cols;
                            weight_next    = cmd_data.value;
                            feat_base_next = FEAT_AW'(cmd_data.source_node)
                                           * FEAT_AW'(MAX_FEATURE_WIDTH);
                            acc_base_next  = ACC_AW'(cmd_data.target_node)
                                           * ACC_AW'(MAX_FEATURE_WIDTH);
                            sat_next       = 1'b0;
                            state_next     = B_EDGE;
                        end
                        OP_READ:
                        begin
                            // Read-first RAM: old value comes out, zero goes in.
                            acc_we     = 1'b1;
                            acc_waddr  = read_addr;
                            acc_wdata  = '0;
                            acc_raddr  = read_addr;
                            state_next = B_READ;
                        end
                        default:
                        begin
                            res_next   = '{read_value: '0, status: STATUS_RANGE};
                            state_next = B_DONE;
                        end
                    endcase
                end
            end
            B_EDGE:
            begin
                if (issue)
                begin
                    j_next = j_reg + 1'b1;
                end
                else if (!s1_valid_reg && !s2_valid_reg)
                begin
                    res_next   = '{read_value: '0,
                                   status: (sat_reg ? STATUS_SAT : STATUS_OK)};
                    state_next = B_DONE;
                end
            end
            B_READ:
            begin
                res_next   = '{read_value: acc_rdata, status: STATUS_OK};
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg         <= j_next;
        fw_reg        <= fw_next;
        weight_reg    <= weight_next;
        feat_base_reg <= feat_base_next;
        acc_base_reg  <= acc_base_next;
        s1_addr_reg   <= s1_addr_next;
        s2_addr_reg   <= s2_addr_next;
        prod_reg      <= prod_next;
        acc_hold_reg  <= acc_hold_next;
        sat_reg       <= sat_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

    assign clearing  = (state_reg == B_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_no_pop_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !cmd_pop
    ) else $error("command taken during accumulator clearing pass");

    a_writeback_only_in_edge: assert property (
        @(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (state_reg == B_EDGE)
    ) else $error("accumulator write-back outside an edge");

    a_edge_write_from_pipe: assert property (
        @(posedge clk) disable iff (!rst_n)
        (acc_we && (state_reg == B_EDGE)) |-> s2_valid_reg
    ) else $error("accumulator written during an edge without a pipeline item");

    a_done_delivers: assert property (
        @(posedge clk) disable iff (!rst_n)
        ((state_reg == B_DONE) && (!out_valid_reg || out_ready))
            |=> (out_valid_reg && (state_reg == B_IDLE))
    ) else $error("finished result not moved into the output register");

endmodule

// ----- rtl/core/weighted_edge_scatter_accumulate.sv -----
// ----------------------------------------------------------------------------
// Weighted edge scatter-accumulate
// COO sparse matrix times dense feature matrix for graph neighbor aggregation,
// in Q16.16 fixed point with saturating accumulation.
// ----------------------------------------------------------------------------
// After reset the block sweeps the accumulator memory to zero, one entry per
// cycle, over MAX_TARGET_NODES * MAX_FEATURE_WIDTH entries (65536 at the
// default sizes); in_ready stays low during that pass, while configuration
// writes are taken at any time. Each item then yields exactly one result item.
// The back end pops an accepted item from the command queue; a load or a
// rejected item (index out of range or unused mode) goes straight to the done
// state, and a read-and-clear passes through a read state first. An edge
// walks the columns through a single multiply-accumulate pipeline on one read
// and one write port of the accumulator memory, starting one column per
// cycle, and waits for the last write-back before the next command. From the
// done state the result moves into the output register once that is free. A
// two-entry command queue sits between the front end and the back end, and the
// output register holds a finished result, so items keep arriving while a
// result waits to be taken.
// ----------------------------------------------------------------------------
module weighted_edge_scatter_accumulate #(
    parameter int MAX_TARGET_NODES  = 1024,
    parameter int MAX_SOURCE_NODES  = 1024,
    parameter int MAX_FEATURE_WIDTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wesa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wesa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  wesa_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output wesa_pkg::out_item_t              out_data
);
    import wesa_pkg::*;

    // Front end to queue.
    logic cmd_push;
    cmd_t cmd_push_data;
    logic queue_full;

    // Queue to back end.
    logic cmd_avail;
    logic cmd_pop;
    cmd_t cmd_pop_data;

    // High while the back end runs its post-reset clearing pass.
    logic clearing;

    // The front end checks the indices each mode uses against the current register
    // values, so the back end receives out-of-range items already marked as rejected.
    wesa_front #(
        .MAX_TARGET_NODES  (MAX_TARGET_NODES),
        .MAX_SOURCE_NODES  (MAX_SOURCE_NODES),
        .MAX_FEATURE_WIDTH (MAX_FEATURE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .clearing   (clearing),
        .queue_full (queue_full),
        .cmd_push   (cmd_push),
        .cmd_data   (cmd_push_data)
    );

    wesa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_push_data),
        .full      (queue_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_pop_data),
        .avail     (cmd_avail)
    );

    // The back end owns both memories and the output register; it executes
    // one command at a time in queue order.
    wesa_back #(
        .MAX_TARGET_NODES  (MAX_TARGET_NODES),
        .MAX_SOURCE_NODES  (MAX_SOURCE_NODES),
        .MAX_FEATURE_WIDTH (MAX_FEATURE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_avail),
        .cmd_pop   (cmd_pop),
        .cmd_data  (cmd_pop_data),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- tb/scatter_scoreboard_pkg.sv -----
// ----------------------------------------------------------------------------
// Scatter-accumulate scoreboard
// Keeps its own copy of the feature and accumulator memories and of the
// configuration registers, predicts the result of every accepted item and
// checks the results in order.
// ----------------------------------------------------------------------------
package scatter_scoreboard_pkg;

    import wesa_pkg::*;

    localparam int TB_TARGET_ROWS  = 1024;
    localparam int TB_SOURCE_ROWS  = 1024;
    localparam int TB_FEATURE_COLS = 64;

    // The mode code that the block leaves unused.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    class scatter_scoreboard;

        bit [VALUE_W-1:0]   feature_mem [TB_SOURCE_ROWS * TB_FEATURE_COLS];
        bit [VALUE_W-1:0]   accum_mem [TB_TARGET_ROWS * TB_FEATURE_COLS];
        logic [COUNT_W-1:0] target_count;
        logic [COUNT_W-1:0] source_count;
        logic [FW_W-1:0]    feature_width;
        out_item_t          due_results [$];
        int                 mismatches;
        int                 matched;

        function new();
            target_count  = TARGET_COUNT_RESET;
            source_count  = SOURCE_COUNT_RESET;
            feature_width = FEATURE_WIDTH_RESET;
            mismatches    = 0;
            matched       = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_TARGET_COUNT:  target_count = data[COUNT_W-1:0];
                CFG_SOURCE_COUNT:  source_count = data[COUNT_W-1:0];
                CFG_FEATURE_WIDTH: feature_width = data[FW_W-1:0];
                default: ;
            endcase
        endfunction

        // Registers act as their maximum when written above it.
        function int target_rows();
            return (int'(target_count) > TB_TARGET_ROWS) ? TB_TARGET_ROWS : int'(target_count);
        endfunction

        function int source_rows();
            return (int'(source_count) > TB_SOURCE_ROWS) ? TB_SOURCE_ROWS : int'(source_count);
        endfunction

        function int feature_cols();
            return (int'(feature_width) > TB_FEATURE_COLS) ? TB_FEATURE_COLS
                                                            : int'(feature_width);
        endfunction

        function int owed();
            return due_results.size();
        endfunction

        // Applies one accepted item to the memories and queues its result.
        function void note_item(in_item_t it);
            out_item_t res;
            int        p;
            int        q;
            int        c;
            int        j;
            int        acc_at;
            longint    sum;
            longint    sat_hi;
            longint    sat_lo;
            p = int'(it.target_node);
            q = int'(it.source_node);
            c = int'(it.column);
            sat_hi = longint'($signed(Q_MAX));
            sat_lo = longint'($signed(Q_MIN));
            res.read_value = '0;
            res.status     = STATUS_OK;
            case (it.mode)
                MODE_LOAD:
                begin
                    if (q < source_rows() && c < feature_cols())
                        feature_mem[q * TB_FEATURE_COLS + c] = it.value;
                    else
                        res.status = STATUS_RANGE;
                end
                MODE_EDGE:
                begin
                    if (p < target_rows() && q < source_rows())
                    begin
                        // Q16.16 product, low 16 bits dropped (floor), then a
                        // saturating add into the 32-bit accumulator.
                        for (j = 0; j < feature_cols(); j++)
                        begin
                            acc_at = p * TB_FEATURE_COLS + j;
                            sum = longint'($signed(accum_mem[acc_at]))
                                + ((longint'($signed(it.value))
                                   * longint'($signed(feature_mem[q * TB_FEATURE_COLS + j])))
                                   >>> 16);
                            if (sum > sat_hi)
                            begin
                                sum = sat_hi;
                                res.status = STATUS_SAT;
                            end
                            else if (sum < sat_lo)
                            begin
                                sum = sat_lo;
                                res.status = STATUS_SAT;
                            end
                            accum_mem[acc_at] = sum[VALUE_W-1:0];
                        end
                    end
                    else
                    begin
                        res.status = STATUS_RANGE;
                    end
                end
                MODE_READ:
                begin
                    if (p < target_rows() && c < feature_cols())
                    begin
                        acc_at = p * TB_FEATURE_COLS + c;
                        res.read_value = accum_mem[acc_at];
                        accum_mem[acc_at] = '0;
                    end
                    else
                    begin
                        res.status = STATUS_RANGE;
                    end
                end
                default: res.status = STATUS_RANGE;
            endcase
            due_results.push_back(res);
        endfunction

        task report(string msg);
            $display("mismatch %0d: %s", mismatches + 1, msg);
            mismatches++;
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("unexpected result, read_value %h status %0d",
                                 got.read_value, got.status));
                return;
            end
            want = due_results.pop_front();
            matched++;
            if (got.read_value !== want.read_value)
                report($sformatf("result %0d read_value %h, predicted %h",
                                 matched, got.read_value, want.read_value));
            if (got.status !== want.status)
                report($sformatf("result %0d status %0d, predicted %0d",
                                 matched, got.status, want.status));
        endtask

    endclass

endpackage

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Weighted edge scatter-accumulate testbench
// Drives load, edge and read items through the valid/ready input channel,
// changes the node counts and feature width between phases, and compares
// every result item with the scoreboard's prediction. Both channels idle at
// random, and once the receiver holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;

    import wesa_pkg::*;
    import scatter_scoreboard_pkg::*;

    // The idle watchdog must outlast the accumulator clearing pass that follows
    // reset (one entry per cycle over the whole accumulator memory).
    localparam int WATCHDOG_LIMIT = 300000;
    // Long receiver hold-off, in cycles, used once to fill the block up.
    localparam int HOLD_CYCLES    = 300;
    // Quiet cycles after the last result: more than the slowest edge takes.
    localparam int TAIL_CYCLES    = 100;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_TARGET_COUNT;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;

    scatter_scoreboard board = new();

    // Which feature elements have been loaded. An edge is only sent for a
    // source row whose columns in use are all loaded, since the block's
    // feature memory holds no defined value before a load.
    bit  loaded [TB_SOURCE_ROWS][TB_FEATURE_COLS];
    int  items_sent     = 0;
    int  idle_cycles    = 0;
    bit  quiet_phase    = 1'b0;
    bit  long_hold_done = 1'b0;

    weighted_edge_scatter_accumulate #(
        .MAX_TARGET_NODES  (TB_TARGET_ROWS),
        .MAX_SOURCE_NODES  (TB_SOURCE_ROWS),
        .MAX_FEATURE_WIDTH (TB_FEATURE_COLS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap lengths shared by sender and receiver: mostly none or short, now and
    // then long. A quiet phase runs both sides back to back.
    function automatic int pick_gap();
        int r;
        if (quiet_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(16, 60);
    endfunction

    // Q16.16 values: small ones that accumulate without saturating, medium
    // ones, the corner values, and raw 32-bit patterns.
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return VALUE_W'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
        if (r < 55)
            return VALUE_W'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
        if (r < 70)
        begin
            case ($urandom_range(0, 5))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                4: return 32'h0001_0000;
                default: return 32'hFFFF_0000;
            endcase
        end
        return VALUE_W'($urandom);
    endfunction

    // Rows mostly come from a small hot set so that edges pile up on the same
    // accumulators; the top row and rows past the count show up too.
    function automatic logic [NODE_W-1:0] pick_row(int count);
        int r;
        r = $urandom_range(0, 99);
        if (count <= 0)
            return NODE_W'($urandom);
        if (r < 5 && count < 1024)
            return NODE_W'($urandom_range(count, 1023));
        if (r < 15)
            return NODE_W'(count - 1);
        if (r < 27)
            return NODE_W'($urandom_range(0, count - 1));
        return NODE_W'($urandom_range(0, (count < 8) ? count - 1 : 7));
    endfunction

    function automatic logic [COL_W-1:0] pick_col();
        int r;
        int cols;
        r = $urandom_range(0, 99);
        cols = board.feature_cols();
        if (cols == 0 || r < 7)
            return COL_W'($urandom);
        if (r < 15 && cols < TB_FEATURE_COLS)
            return COL_W'($urandom_range(cols, TB_FEATURE_COLS - 1));
        return COL_W'($urandom_range(0, cols - 1));
    endfunction

    function automatic bit row_ready(logic [NODE_W-1:0] q);
        int c;
        for (c = 0; c < board.feature_cols(); c++)
        begin
            if (!loaded[q][c])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic in_item_t pack_item(logic [MODE_W-1:0] m, logic [NODE_W-1:0] p,
                                           logic [NODE_W-1:0] q, logic [COL_W-1:0] c,
                                           logic [VALUE_W-1:0] v);
        in_item_t it;
        it.mode        = m;
        it.target_node = p;
        it.source_node = q;
        it.column      = c;
        it.value       = v;
        return it;
    endfunction

    // Offers one item after a random gap and holds it until it is accepted.
    // Called at a rising edge; valid is only lowered when a gap follows, so a
    // back-to-back item never sees valid dropped and raised in one step.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_item(it);
        items_sent++;
    endtask

    // Sends an item and keeps the load map in step with it. The map follows
    // program order, which is the order the block applies items in.
    task automatic offer(input in_item_t it);
        if (it.mode == MODE_LOAD && int'(it.source_node) < board.source_rows()
            && int'(it.column) < board.feature_cols())
            loaded[it.source_node][it.column] = 1'b1;
        send_item(it);
    endtask

    task automatic load_row(input logic [NODE_W-1:0] q);
        int c;
        for (c = 0; c < board.feature_cols(); c++)
            offer(pack_item(MODE_LOAD, NODE_W'($urandom), q, COL_W'(c), pick_value()));
    endtask

    // Stops offering and waits until every predicted result has come back, so
    // the block is idle before its registers change.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.owed() != 0)
            @(posedge clk);
    endtask

    // Writes all three registers on consecutive cycles; write enable drops
    // only after the last one.
    task automatic configure(int tc, int sc, int fw);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TARGET_COUNT;
        cfg_wdata <= CFG_DATA_W'(tc);
        board.set_reg(CFG_TARGET_COUNT, CFG_DATA_W'(tc));
        @(posedge clk);
        cfg_index <= CFG_SOURCE_COUNT;
        cfg_wdata <= CFG_DATA_W'(sc);
        board.set_reg(CFG_SOURCE_COUNT, CFG_DATA_W'(sc));
        @(posedge clk);
        cfg_index <= CFG_FEATURE_WIDTH;
        cfg_wdata <= CFG_DATA_W'(fw);
        board.set_reg(CFG_FEATURE_WIDTH, CFG_DATA_W'(fw));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random items under the current setting. Most are loads, edges and reads
    // on the hot rows; an edge on a row that is not fully loaded is preceded
    // by loads of the whole row. About one item in ten is raw noise.
    task automatic run_random(int count);
        int             stop_at;
        int             r;
        in_item_t       it;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            r  = $urandom_range(0, 99);
            it = pack_item(MODE_READ, pick_row(board.target_rows()),
                           pick_row(board.source_rows()), pick_col(), pick_value());
            if (r < 10)
            begin
                it.mode        = MODE_W'($urandom);
                it.target_node = NODE_W'($urandom);
                it.source_node = NODE_W'($urandom);
                it.column      = COL_W'($urandom);
                it.value       = VALUE_W'($urandom);
                // A noise edge must not touch unloaded features.
                if (it.mode == MODE_EDGE && int'(it.target_node) < board.target_rows()
                    && int'(it.source_node) < board.source_rows()
                    && !row_ready(it.source_node))
                    it.mode = MODE_UNUSED;
            end
            else if (r < 35)
            begin
                it.mode = MODE_LOAD;
            end
            else if (r < 70)
            begin
                it.mode = MODE_EDGE;
                if (int'(it.target_node) < board.target_rows()
                    && int'(it.source_node) < board.source_rows()
                    && !row_ready(it.source_node))
                    load_row(it.source_node);
            end
            offer(it);
        end
    endtask

    task automatic run_phase(int tc, int sc, int fw, int count);
        drain();
        configure(tc, sc, fw);
        quiet_phase = ($urandom_range(0, 4) == 0);
        run_random(count);
    endtask

    // Sender and phase sequence.
    initial
    begin
        int k;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at the reset setting: one column, all rows in range.
        // Corner values are loaded and then pushed through edges that saturate
        // upward and downward, land exactly on the negative limit, and drop
        // the fraction of a negative product toward minus infinity.
        offer(pack_item(MODE_LOAD, 10'd0,    10'd1023, 6'd0,  Q_MAX));
        offer(pack_item(MODE_LOAD, 10'd1023, 10'd0,    6'd0,  Q_MIN));
        offer(pack_item(MODE_LOAD, 10'd5,    10'd2,    6'd0,  32'hFFFF_FFFF));
        offer(pack_item(MODE_LOAD, 10'd0,    10'd3,    6'd63, 32'h1234_5678));
        offer(pack_item(MODE_EDGE, 10'd1023, 10'd1023, 6'd0,  Q_MAX));
        offer(pack_item(MODE_EDGE, 10'd1023, 10'd1023, 6'd0,  32'h0001_0000));
        offer(pack_item(MODE_READ, 10'd1023, 10'd0,    6'd0,  32'h0));
        offer(pack_item(MODE_READ, 10'd1023, 10'd0,    6'd0,  32'h0));
        offer(pack_item(MODE_EDGE, 10'd0,    10'd0,    6'd0,  Q_MIN));
        offer(pack_item(MODE_READ, 10'd0,    10'd0,    6'd0,  32'h0));
        offer(pack_item(MODE_EDGE, 10'd1,    10'd0,    6'd0,  32'h0001_0000));
        offer(pack_item(MODE_EDGE, 10'd1,    10'd0,    6'd0,  32'h0001_0000));
        offer(pack_item(MODE_READ, 10'd1,    10'd0,    6'd0,  32'h0));
        offer(pack_item(MODE_EDGE, 10'd2,    10'd2,    6'd0,  32'h0000_8000));
        offer(pack_item(MODE_READ, 10'd2,    10'd0,    6'd0,  32'h0));
        offer(pack_item(MODE_READ, 10'd2,    10'd0,    6'd1,  32'h0));
        offer(pack_item(MODE_UNUSED, 10'd7,  10'd7,    6'd7,  32'hDEAD_BEEF));

        // Zero feature width: an in-range edge changes nothing and succeeds, while
        // edges on rows past the counts and any load or read are refused.
        drain();
        configure(1000, 1000, 0);
        offer(pack_item(MODE_EDGE, 10'd5,    10'd5,    6'd0,  32'h0001_0000));
        offer(pack_item(MODE_EDGE, 10'd1010, 10'd0,    6'd0,  32'h0001_0000));
        offer(pack_item(MODE_EDGE, 10'd0,    10'd1010, 6'd0,  32'h0001_0000));
        offer(pack_item(MODE_LOAD, 10'd0,    10'd1010, 6'd0,  32'h0001_0000));
        offer(pack_item(MODE_READ, 10'd0,    10'd0,    6'd0,  32'h0));

        // Widest rows, a small graph, the minimum, values above the maxima,
        // zero counts, random small settings and finally the 1-D case.
        run_phase(1024, 1024, 64, 150);
        run_phase(8, 8, 4, 300);
        run_phase(1, 1, 1, 80);
        run_phase(2047, 2047, 127, 100);
        run_phase(0, 0, 0, 40);
        for (k = 0; k < 4; k++)
            run_phase($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 16), 180);
        run_phase(1024, 1024, 1, 150);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.owed() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off once a few hundred
    // results have passed, while the sender keeps offering items. The command
    // queue and output register fill, and the block must stall its input.
    initial
    begin
        int gap;
        int run_len;
        wait (rst_n);
        forever
        begin
            if (!long_hold_done && board.matched >= 400)
            begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            run_len = $urandom_range(1, 12);
            repeat (run_len) @(posedge clk);
        end
    end

    // Result monitor: values sampled at the edge are the ones before it.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            board.check_result(out_data);
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
